>>> rtl/core/adfp_pkg.sv
`timescale 1ns / 1ps

package adfp_pkg;

    // Field and datapath widths.
    localparam int CHAR_W  = 8;
    localparam int ACC_W   = 60;
    localparam int MANT_W  = 61;
    localparam int CNT_W   = 5;
    localparam int DIGIT_W = 4;

    // Largest number of decimal digits held in the accumulator.
    localparam logic [CNT_W-1:0] MAX_DIGITS = 5'd18;

    // Largest magnitude, ten to the eighteenth minus one.
    localparam logic [ACC_W-1:0] ACC_TOP = 60'd999999999999999999;

    // Any accumulator at or above ten to the seventeenth overflows on the next digit.
    localparam logic [ACC_W-1:0] ACC_SAT_FROM = 60'd100000000000000000;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // Parse phases.
    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_INT   = 2'd1,
        PH_FRAC  = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    // Parser state carried from one character to the next.
    typedef struct packed {
        t_phase             phase;
        logic               neg;
        logic [ACC_W-1:0]   acc;
        logic [CNT_W-1:0]   frac_cnt;
        logic               ovf;
    } t_parse;

    localparam t_parse PARSE_CLEAR = '{
        phase:    PH_START,
        neg:      1'b0,
        acc:      '0,
        frac_cnt: '0,
        ovf:      1'b0
    };

endpackage

>>> rtl/core/adfp_step.sv
`timescale 1ns / 1ps

module adfp_step (
    input  adfp_pkg::t_parse                 i_state,
    input  logic [adfp_pkg::CHAR_W-1:0]      i_char,
    input  logic [adfp_pkg::CNT_W-1:0]       i_frac_limit,
    output adfp_pkg::t_parse                 o_state
);

    logic                           is_digit;
    logic                           is_minus;
    logic                           is_point;
    logic [adfp_pkg::DIGIT_W-1:0]   digit;
    logic [adfp_pkg::CNT_W-1:0]     eff_limit;
    logic [adfp_pkg::CNT_W-1:0]     frac_inc;
    logic                           take;
    logic                           sat;
    logic [63:0]                    acc_wide;
    logic [63:0]                    acc_x10;
    logic [adfp_pkg::ACC_W-1:0]     acc_take;
    adfp_pkg::t_phase               n_phase;

    // Character classes.
    assign is_digit = (i_char >= adfp_pkg::CHAR_ZERO) && (i_char <= adfp_pkg::CHAR_NINE);
    assign is_minus = (i_char == adfp_pkg::CHAR_MINUS);
    assign is_point = (i_char == adfp_pkg::CHAR_POINT);
    assign digit    = i_char[adfp_pkg::DIGIT_W-1:0];

    // A limit of zero or above the block maximum means the block maximum.
    assign eff_limit = ((i_frac_limit == '0) || (i_frac_limit > adfp_pkg::MAX_DIGITS)) ?
                       adfp_pkg::MAX_DIGITS : i_frac_limit;
    assign frac_inc  = i_state.frac_cnt + 5'd1;

    // A digit is taken in every phase but done.
    assign take = is_digit && (i_state.phase != adfp_pkg::PH_DONE);

    // Multiply by ten as two shifts and an add, then add the digit.
    assign sat      = (i_state.acc >= adfp_pkg::ACC_SAT_FROM);
    assign acc_wide = {4'b0, i_state.acc};
    assign acc_x10  = (acc_wide << 3) + (acc_wide << 1) + {60'b0, digit};
    assign acc_take = sat ? adfp_pkg::ACC_TOP : acc_x10[adfp_pkg::ACC_W-1:0];

    // Next parse phase.
    always_comb begin
        n_phase = i_state.phase;
        case (i_state.phase)
            adfp_pkg::PH_START: begin
                if (is_minus || is_digit) begin
                    n_phase = adfp_pkg::PH_INT;
                end else if (is_point) begin
                    n_phase = adfp_pkg::PH_FRAC;
                end else begin
                    n_phase = adfp_pkg::PH_DONE;
                end
            end
            adfp_pkg::PH_INT: begin
                if (is_point) begin
                    n_phase = adfp_pkg::PH_FRAC;
                end else if (!is_digit) begin
                    n_phase = adfp_pkg::PH_DONE;
                end
            end
            adfp_pkg::PH_FRAC: begin
                if (!is_digit || (frac_inc >= eff_limit)) begin
                    n_phase = adfp_pkg::PH_DONE;
                end
            end
            default: begin
                n_phase = adfp_pkg::PH_DONE;
            end
        endcase
    end

    // Datapath updates that follow from the current phase and character.
    always_comb begin
        o_state       = i_state;
        o_state.phase = n_phase;
        if ((i_state.phase == adfp_pkg::PH_START) && is_minus) begin
            o_state.neg = 1'b1;
        end
        if (take) begin
            o_state.acc = acc_take;
            if (sat) begin
                o_state.ovf = 1'b1;
            end
        end
        if (take && (i_state.phase == adfp_pkg::PH_FRAC)) begin
            o_state.frac_cnt = frac_inc;
        end
    end

endmodule

>>> rtl/core/ascii_decimal_to_fixed_point.sv
`timescale 1ns / 1ps
// A result is registered once the character marked last has passed the input register and been parsed.
// Throughput: one character per cycle while the input is not stalled, set by the single multiply-by-ten step.
// The input stalls only while a result is held by output stall and a last character waits.
// Reset (synchronous, active low) clears the parser, the fraction limit and both valid flags.

module ascii_decimal_to_fixed_point (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Character channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [adfp_pkg::CHAR_W-1:0]            i_char_code,
    input  logic                                   i_last_char,
    // Result channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [adfp_pkg::MANT_W-1:0]     o_mantissa,
    output logic [adfp_pkg::CNT_W-1:0]             o_fraction_count,
    output logic                                   o_overflow,
    // Configuration channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [adfp_pkg::CNT_W-1:0]             i_cfg_fraction_limit
);

    logic                               r_in_vld;
    logic [adfp_pkg::CHAR_W-1:0]        r_in_char;
    logic                               r_in_last;
    adfp_pkg::t_parse                   r_state;
    adfp_pkg::t_parse                   n_state;
    logic [adfp_pkg::CNT_W-1:0]         r_frac_limit;
    logic                               r_out_vld;
    logic [adfp_pkg::MANT_W-1:0]        r_out_mant;
    logic [adfp_pkg::CNT_W-1:0]         r_out_cnt;
    logic                               r_out_ovf;
    logic                               out_busy;
    logic                               proc_ok;
    logic [adfp_pkg::MANT_W-1:0]        mag;
    logic [adfp_pkg::MANT_W-1:0]        n_mant;

    // Handshake: a held result blocks only a waiting last character.
    assign out_busy    = r_out_vld && i_stall;
    assign proc_ok     = r_in_vld && !(r_in_last && out_busy);
    assign o_stall     = r_in_vld && r_in_last && out_busy;
    assign o_cfg_ready = 1'b1;

    // Parse step for the registered character.
    adfp_step u_step (
        .i_state      (r_state),
        .i_char       (r_in_char),
        .i_frac_limit (r_frac_limit),
        .o_state      (n_state)
    );

    // Signed mantissa from the updated magnitude.
    assign mag    = {1'b0, n_state.acc};
    assign n_mant = n_state.neg ? ('0 - mag) : mag;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
        if (i_valid && !o_stall) begin
            r_in_char <= i_char_code;
            r_in_last <= i_last_char;
        end
    end

    // Parser state and fraction limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= adfp_pkg::PARSE_CLEAR;
            r_frac_limit <= '0;
        end else begin
            if (proc_ok) begin
                r_state <= r_in_last ? adfp_pkg::PARSE_CLEAR : n_state;
            end
            if (i_cfg_valid) begin
                r_frac_limit <= i_cfg_fraction_limit;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc_ok && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
        if (proc_ok && r_in_last) begin
            r_out_mant <= n_mant;
            r_out_cnt  <= n_state.frac_cnt;
            r_out_ovf  <= n_state.ovf;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_mantissa       = r_out_mant;
    assign o_fraction_count = r_out_cnt;
    assign o_overflow       = r_out_ovf;

endmodule
